>>> hw/rtl/ptst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic tick slot table package
// Shared sizes, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int TOP_W       = 7;
    localparam int PERIOD_W    = 32;
    localparam int BIT_W       = 5;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ATTACH = 2'd1,
        OP_DETACH = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_FIRED        = 3'd0,
        ST_NONE         = 3'd1,
        ST_ATTACHED     = 3'd2,
        ST_FULL         = 3'd3,
        ST_ZERO         = 3'd4,
        ST_DETACHED     = 3'd5,
        ST_NOT_ATTACHED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_TRIM,
        S_SCAN,
        S_DIV,
        S_HIT,
        S_TEND,
        S_EMIT
    } state_t;

endpackage

>>> hw/rtl/periodic_tick_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic tick slot table
// Holds periodic slots and reports on each tick which slots expire.
// ----------------------------------------------------------------------------
// Attach and detach walk the table (find a free slot, trim the top mark) before
// the result item; an attach with a zero period or a detach of a free slot skips it.
// A tick visits every slot below top, and for each occupied slot the
// remainder is found by a bit-serial restoring divider, one bit a cycle.
// The block takes one item at a time, and output stalls hold it.
// Reset (rst_n low) frees every slot and clears the top mark and tick counter.
module periodic_tick_slot_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // period[31:0], slot[37:32], zero[39:38]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // slot_index[5:0], zero[7:6]
    output logic [2:0]  m_axis_tuser,  // status[2:0]
    output logic        m_axis_tlast
);

    localparam logic [ptst_pkg::BIT_W-1:0] DIV_LAST = '1;
    localparam logic [ptst_pkg::TOP_W-1:0] TOP_MAX =
        ptst_pkg::TOP_W'(ptst_pkg::TABLE_DEPTH);

    ptst_pkg::state_t                    state_reg, state_next;
    logic [ptst_pkg::TOP_W-1:0]          idx_reg, idx_next;
    logic [ptst_pkg::TOP_W-1:0]          top_reg, top_next;
    logic [ptst_pkg::PERIOD_W-1:0]       tick_reg, tick_next;
    logic [ptst_pkg::TABLE_DEPTH-1:0]    used_reg, used_next;
    logic [ptst_pkg::PERIOD_W-1:0]       period_reg, period_next;
    logic [ptst_pkg::PERIOD_W-1:0]       rem_reg, rem_next;
    logic [ptst_pkg::PERIOD_W-1:0]       shift_reg, shift_next;
    logic [ptst_pkg::BIT_W-1:0]          bit_reg, bit_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [ptst_pkg::IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    ptst_pkg::status_t                   res_status_reg, res_status_next;
    logic [ptst_pkg::IDX_W-1:0]          res_idx_reg, res_idx_next;
    logic                                out_valid_reg, out_valid_next;
    ptst_pkg::status_t                   out_status_reg, out_status_next;
    logic [ptst_pkg::IDX_W-1:0]          out_idx_reg, out_idx_next;
    logic                                out_last_reg, out_last_next;

    logic [ptst_pkg::PERIOD_W-1:0]       mem [ptst_pkg::TABLE_DEPTH];
    logic [ptst_pkg::PERIOD_W-1:0]       rd_data_reg;
    logic                                mem_we;
    logic [ptst_pkg::IDX_W-1:0]          mem_waddr;

    logic                                in_fire;
    ptst_pkg::op_t                       in_op;
    logic [ptst_pkg::PERIOD_W-1:0]       in_period;
    logic [ptst_pkg::IDX_W-1:0]          in_slot;
    logic                                detach_bad;
    logic                                out_free;
    logic                                idx_at_top;
    logic                                idx_used;
    logic [ptst_pkg::TOP_W-1:0]          top_less;
    logic                                top_prev_used;
    logic [ptst_pkg::PERIOD_W:0]         rem_wide;
    logic [ptst_pkg::PERIOD_W:0]         rem_sub;
    logic [ptst_pkg::PERIOD_W-1:0]       rem_new;
    logic                                hit_push;

    assign in_op      = ptst_pkg::op_t'(s_axis_tuser);
    assign in_period  = s_axis_tdata[31:0];
    assign in_slot    = s_axis_tdata[37:32];
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign detach_bad = ({1'b0, in_slot} >= TOP_MAX) || !used_reg[in_slot];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign idx_at_top    = (idx_reg == top_reg);
    assign idx_used      = used_reg[idx_reg[ptst_pkg::IDX_W-1:0]];
    assign top_less      = top_reg - 1'b1;
    assign top_prev_used = used_reg[top_less[ptst_pkg::IDX_W-1:0]];

    // One step of restoring division: shift in the next dividend bit.
    assign rem_wide = {rem_reg, shift_reg[ptst_pkg::PERIOD_W-1]};
    assign rem_sub  = rem_wide - {1'b0, rd_data_reg};
    assign rem_new  = (rem_wide >= {1'b0, rd_data_reg}) ?
                      rem_sub[ptst_pkg::PERIOD_W-1:0] : rem_wide[ptst_pkg::PERIOD_W-1:0];

    // A fired slot with another already pending pushes the pending one out.
    assign hit_push = (rem_reg == '0) && pend_valid_reg;

    assign s_axis_tready = (state_reg == ptst_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_idx_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptst_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        ptst_pkg::OP_TICK:   state_next = ptst_pkg::S_SCAN;
                        ptst_pkg::OP_ATTACH: state_next = (in_period == '0) ?
                                                 ptst_pkg::S_EMIT : ptst_pkg::S_FIND;
                        ptst_pkg::OP_DETACH: state_next = detach_bad ?
                                                 ptst_pkg::S_EMIT : ptst_pkg::S_TRIM;
                        default:             state_next = ptst_pkg::S_IDLE;
                    endcase
                end
            end
            ptst_pkg::S_FIND:
            begin
                if (idx_at_top || !idx_used)
                    state_next = ptst_pkg::S_EMIT;
            end
            ptst_pkg::S_TRIM:
            begin
                if (top_reg == '0 || top_prev_used)
                    state_next = ptst_pkg::S_EMIT;
            end
            ptst_pkg::S_SCAN:
            begin
                if (idx_at_top)
                    state_next = ptst_pkg::S_TEND;
                else if (idx_used)
                    state_next = ptst_pkg::S_DIV;
            end
            ptst_pkg::S_DIV:
            begin
                if (bit_reg == DIV_LAST)
                    state_next = ptst_pkg::S_HIT;
            end
            ptst_pkg::S_HIT:
            begin
                if (!hit_push || out_free)
                    state_next = ptst_pkg::S_SCAN;
            end
            ptst_pkg::S_TEND:
            begin
                state_next = ptst_pkg::S_EMIT;
            end
            ptst_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = ptst_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ptst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        top_next        = top_reg;
        tick_next       = tick_reg;
        used_next       = used_reg;
        period_next     = period_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        bit_next        = bit_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[ptst_pkg::IDX_W-1:0];

        unique case (state_reg)
            ptst_pkg::S_IDLE:
            begin
                idx_next        = '0;
                pend_valid_next = 1'b0;
                period_next     = in_period;
                if (in_fire)
                begin
                    case (in_op)
                        ptst_pkg::OP_ATTACH:
                        begin
                            res_status_next = ptst_pkg::ST_ZERO;
                            res_idx_next    = '0;
                        end
                        ptst_pkg::OP_DETACH:
                        begin
                            res_idx_next = in_slot;
                            if (detach_bad)
                                res_status_next = ptst_pkg::ST_NOT_ATTACHED;
                            else
                            begin
                                res_status_next    = ptst_pkg::ST_DETACHED;
                                used_next[in_slot] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ptst_pkg::S_FIND:
            begin
                if (idx_at_top)
                begin
                    if (top_reg < TOP_MAX)
                    begin
                        mem_we          = 1'b1;
                        used_next[top_reg[ptst_pkg::IDX_W-1:0]] = 1'b1;
                        top_next        = top_reg + 1'b1;
                        res_status_next = ptst_pkg::ST_ATTACHED;
                        res_idx_next    = top_reg[ptst_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        res_status_next = ptst_pkg::ST_FULL;
                        res_idx_next    = '0;
                    end
                end
                else if (!idx_used)
                begin
                    mem_we          = 1'b1;
                    used_next[idx_reg[ptst_pkg::IDX_W-1:0]] = 1'b1;
                    res_status_next = ptst_pkg::ST_ATTACHED;
                    res_idx_next    = idx_reg[ptst_pkg::IDX_W-1:0];
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ptst_pkg::S_TRIM:
            begin
                if (top_reg != '0 && !top_prev_used)
                    top_next = top_less;
            end
            ptst_pkg::S_SCAN:
            begin
                rem_next   = '0;
                shift_next = tick_reg;
                bit_next   = '0;
                if (!idx_at_top && !idx_used)
                    idx_next = idx_reg + 1'b1;
            end
            ptst_pkg::S_DIV:
            begin
                rem_next   = rem_new;
                shift_next = {shift_reg[ptst_pkg::PERIOD_W-2:0], 1'b0};
                bit_next   = bit_reg + 1'b1;
            end
            ptst_pkg::S_HIT:
            begin
                if (rem_reg != '0)
                    idx_next = idx_reg + 1'b1;
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ptst_pkg::ST_FIRED;
                        out_idx_next    = pend_idx_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[ptst_pkg::IDX_W-1:0];
                    idx_next        = idx_reg + 1'b1;
                end
            end
            ptst_pkg::S_TEND:
            begin
                tick_next       = tick_reg + 1'b1;
                pend_valid_next = 1'b0;
                res_status_next = pend_valid_reg ? ptst_pkg::ST_FIRED : ptst_pkg::ST_NONE;
                res_idx_next    = pend_valid_reg ? pend_idx_reg : '0;
            end
            ptst_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptst_pkg::S_IDLE;
            top_reg        <= '0;
            tick_reg       <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            tick_reg       <= tick_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        period_reg     <= period_next;
        rem_reg        <= rem_next;
        shift_reg      <= shift_next;
        bit_reg        <= bit_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= period_reg;
        rd_data_reg <= mem[idx_reg[ptst_pkg::IDX_W-1:0]];
    end

    // The top mark never passes the table depth.
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_MAX)
        else $error("top mark beyond table depth");

    // Between items the top mark sits just above an occupied slot.
    a_top_tight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptst_pkg::S_IDLE && top_reg != '0) |-> top_prev_used)
        else $error("top mark not trimmed");

    // The slot under division does not move while the divider runs.
    a_div_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptst_pkg::S_DIV) |=> $stable(idx_reg))
        else $error("slot index moved during division");

    // No pending fired slot survives the end of a tick.
    a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptst_pkg::S_EMIT) |-> !pend_valid_reg)
        else $error("pending fired slot left behind");

endmodule
